// File: rtl/eam_pkg.sv
// shared types, constants and codes of the energy accounting meter
package eam_pkg;

  localparam int NUM_COMPONENTS = 8;
  localparam int IDX_W          = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

  localparam int FUNC_W    = 2;
  localparam int COMP_W    = 3;
  localparam int TIME_W    = 48;
  localparam int DRAW_W    = 20;
  localparam int CHARGE_W  = 40;
  localparam int CFG_IDX_W = 1;

  localparam int HALF_W  = TIME_W / 2;
  localparam int PP_W    = HALF_W + DRAW_W;
  localparam int PROD_W  = TIME_W + DRAW_W;
  localparam int DIGIT_W = 8;
  localparam int DIV_STEPS = (PROD_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DQ_W    = DIV_STEPS * DIGIT_W;
  localparam int REM_W   = 12;
  localparam int LVL_STEPS = CHARGE_W;
  localparam int CNT_W   = $clog2(LVL_STEPS + 1);

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [TIME_W-1:0]   tstamp_t;
  typedef logic [DRAW_W-1:0]   draw_t;
  typedef logic [CHARGE_W-1:0] charge_t;
  typedef logic [HALF_W-1:0]   half_t;
  typedef logic [PP_W-1:0]     pp_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [DQ_W-1:0]     dq_t;
  typedef logic [REM_W-1:0]    rem_t;
  typedef logic [REM_W:0]      trial_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  localparam trial_t  SECS_PER_HOUR   = 13'd3600;
  localparam charge_t FULL_CHARGE_RST = 40'd1000000000;
  localparam charge_t CPL_RST         = 40'd10000000;
  localparam idx_t    LAST_IDX        = idx_t'(NUM_COMPONENTS - 1);
  localparam cnt_t    DIV_LAST        = cnt_t'(DIV_STEPS - 1);
  localparam cnt_t    LVL_LAST        = cnt_t'(LVL_STEPS - 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ON     = 2'd0,
    FUNC_OFF    = 2'd1,
    FUNC_UPDATE = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_CHARGE      = 1'd0,
    CFG_CHARGE_PER_LEVEL = 1'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_INIT,
    ST_DIV,
    ST_APPLY,
    ST_LVL_INIT,
    ST_LVL,
    ST_LVL_END,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [COMP_W-1:0] component;
    tstamp_t           now_ms;
    draw_t             draw_ua;
  } item_t;

  typedef struct packed {
    charge_t residual;
    charge_t energy_level;
    logic    node_down;
    tstamp_t component_on_time;
  } result_t;

  typedef struct packed {
    logic capture;
    logic idx_clr;
    logic idx_comp;
    logic idx_inc;
    logic load;
    logic mul_en;
    logic mul_hi;
    logic div_init;
    logic div_step;
    logic apply;
    logic lvl_init;
    logic lvl_step;
    logic lvl_end;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              in_range;
    logic              active;
    logic              last_idx;
  } status_t;

endpackage

// File: rtl/eam_ctrl.sv
// sequencing state machine of the energy accounting meter
module eam_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output logic             done_o,
  input  eam_pkg::status_t st_i,
  output eam_pkg::cmd_t    cmd_o
);

  eam_pkg::state_e state_q, state_d;
  eam_pkg::cnt_t   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eam_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      eam_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = eam_pkg::ST_DISPATCH;
        end
      end
      eam_pkg::ST_DISPATCH: begin
        case (st_i.func)
          eam_pkg::FUNC_ON, eam_pkg::FUNC_OFF: begin
            cmd_o.idx_comp = 1'b1;
            state_d = st_i.in_range ? eam_pkg::ST_LOAD : eam_pkg::ST_DONE;
          end
          eam_pkg::FUNC_UPDATE: begin
            cmd_o.idx_clr = 1'b1;
            state_d       = eam_pkg::ST_LOAD;
          end
          default: begin
            cmd_o.idx_comp = 1'b1;
            state_d        = eam_pkg::ST_DONE;
          end
        endcase
      end
      eam_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = st_i.active ? eam_pkg::ST_MUL_LO : eam_pkg::ST_APPLY;
      end
      eam_pkg::ST_MUL_LO: begin
        cmd_o.mul_en = 1'b1;
        state_d      = eam_pkg::ST_MUL_HI;
      end
      eam_pkg::ST_MUL_HI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = 1'b1;
        state_d      = eam_pkg::ST_DIV_INIT;
      end
      eam_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = eam_pkg::ST_DIV;
      end
      eam_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == eam_pkg::DIV_LAST) begin
          state_d = eam_pkg::ST_APPLY;
        end
      end
      eam_pkg::ST_APPLY: begin
        cmd_o.apply = 1'b1;
        if (st_i.func == eam_pkg::FUNC_UPDATE && !st_i.last_idx) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = eam_pkg::ST_LOAD;
        end else begin
          state_d = eam_pkg::ST_LVL_INIT;
        end
      end
      eam_pkg::ST_LVL_INIT: begin
        cmd_o.lvl_init = 1'b1;
        cmd_o.idx_comp = 1'b1;
        cnt_d          = '0;
        state_d        = eam_pkg::ST_LVL;
      end
      eam_pkg::ST_LVL: begin
        cmd_o.lvl_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == eam_pkg::LVL_LAST) begin
          state_d = eam_pkg::ST_LVL_END;
        end
      end
      eam_pkg::ST_LVL_END: begin
        cmd_o.lvl_end = 1'b1;
        state_d       = eam_pkg::ST_DONE;
      end
      eam_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = eam_pkg::ST_IDLE;
      end
      default: begin
        state_d = eam_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/eam_datapath.sv
// component state, charge arithmetic and level divider of the energy accounting meter
module eam_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  eam_pkg::item_t                item_i,
  input  logic                          cfg_wr_i,
  input  logic [eam_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  eam_pkg::charge_t              cfg_data_i,
  input  eam_pkg::cmd_t                 cmd_i,
  output eam_pkg::status_t              st_o,
  output eam_pkg::result_t              result_o
);

  logic              active_q [eam_pkg::NUM_COMPONENTS];
  eam_pkg::tstamp_t  start_q  [eam_pkg::NUM_COMPONENTS];
  eam_pkg::draw_t    draw_q   [eam_pkg::NUM_COMPONENTS];
  eam_pkg::tstamp_t  ontime_q [eam_pkg::NUM_COMPONENTS];

  eam_pkg::charge_t  residual_q, level_q, cpl_q;
  eam_pkg::item_t    item_q;
  eam_pkg::idx_t     idx_q;

  eam_pkg::tstamp_t  elapsed_q;
  eam_pkg::draw_t    draw_sel_q;
  eam_pkg::pp_t      plo_q, phi_q;
  eam_pkg::dq_t      dq_q;
  eam_pkg::rem_t     rem_q;
  eam_pkg::charge_t  lq_q, lrem_q;

  logic              in_range;
  logic              act_sel;
  eam_pkg::tstamp_t  start_sel, ontime_sel;
  eam_pkg::draw_t    draw_sel;
  eam_pkg::half_t    mul_a;
  eam_pkg::pp_t      mul_p;
  eam_pkg::rem_t     rem_t_v;
  eam_pkg::trial_t   trial;
  logic [eam_pkg::DIGIT_W-1:0] qbits;
  eam_pkg::prod_t    used;
  logic              used_big;
  eam_pkg::charge_t  res_new;
  logic [eam_pkg::TIME_W:0]   ot_sum;
  eam_pkg::tstamp_t  ot_new;
  logic [eam_pkg::CHARGE_W:0] lvl_trial, lvl_diff;
  logic              lvl_ge;

  assign in_range   = 32'(item_q.component) < 32'(eam_pkg::NUM_COMPONENTS);
  assign act_sel    = active_q[idx_q];
  assign start_sel  = start_q[idx_q];
  assign draw_sel   = draw_q[idx_q];
  assign ontime_sel = ontime_q[idx_q];

  assign st_o.func     = item_q.func;
  assign st_o.in_range = in_range;
  assign st_o.active   = act_sel;
  assign st_o.last_idx = (idx_q == eam_pkg::LAST_IDX);

  // one shared 24x20 multiplier, low half of the elapsed time first, then the high half
  assign mul_a = cmd_i.mul_hi ? elapsed_q[eam_pkg::TIME_W-1:eam_pkg::HALF_W]
                              : elapsed_q[eam_pkg::HALF_W-1:0];
  assign mul_p = eam_pkg::pp_t'(mul_a) * eam_pkg::pp_t'(draw_sel_q);

  // divide by seconds per hour, one byte of the product per cycle
  always_comb begin
    rem_t_v = rem_q;
    qbits   = '0;
    trial   = '0;
    for (int k = 0; k < eam_pkg::DIGIT_W; k++) begin
      trial = {rem_t_v, dq_q[eam_pkg::DQ_W-1-k]};
      if (trial >= eam_pkg::SECS_PER_HOUR) begin
        trial = trial - eam_pkg::SECS_PER_HOUR;
        qbits[eam_pkg::DIGIT_W-1-k] = 1'b1;
      end
      rem_t_v = trial[eam_pkg::REM_W-1:0];
    end
  end

  assign used     = dq_q[eam_pkg::PROD_W-1:0];
  assign used_big = |used[eam_pkg::PROD_W-1:eam_pkg::CHARGE_W];
  assign res_new  = (used_big || used[eam_pkg::CHARGE_W-1:0] >= residual_q) ? '0
                    : residual_q - used[eam_pkg::CHARGE_W-1:0];
  assign ot_sum   = {1'b0, ontime_sel} + {1'b0, elapsed_q};
  assign ot_new   = ot_sum[eam_pkg::TIME_W] ? '1 : ot_sum[eam_pkg::TIME_W-1:0];

  // restoring divider for the level, one quotient bit per cycle
  assign lvl_trial = {lrem_q, lq_q[eam_pkg::CHARGE_W-1]};
  assign lvl_diff  = lvl_trial - {1'b0, cpl_q};
  assign lvl_ge    = lvl_trial >= {1'b0, cpl_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < eam_pkg::NUM_COMPONENTS; i++) begin
        active_q[i] <= 1'b0;
        start_q[i]  <= '0;
        draw_q[i]   <= '0;
        ontime_q[i] <= '0;
      end
      residual_q <= eam_pkg::FULL_CHARGE_RST;
      cpl_q      <= eam_pkg::CPL_RST;
      level_q    <= '0;
      idx_q      <= '0;
    end else begin
      if (cfg_wr_i) begin
        case (cfg_index_i)
          eam_pkg::CFG_FULL_CHARGE:      residual_q <= cfg_data_i;
          eam_pkg::CFG_CHARGE_PER_LEVEL: cpl_q      <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_comp) begin
        idx_q <= eam_pkg::idx_t'(item_q.component);
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.apply) begin
        // close the open interval, then reopen or leave off
        if (act_sel) begin
          residual_q      <= res_new;
          ontime_q[idx_q] <= ot_new;
        end
        case (item_q.func)
          eam_pkg::FUNC_ON: begin
            active_q[idx_q] <= 1'b1;
            start_q[idx_q]  <= item_q.now_ms;
            draw_q[idx_q]   <= item_q.draw_ua;
          end
          eam_pkg::FUNC_OFF: begin
            active_q[idx_q] <= 1'b0;
          end
          eam_pkg::FUNC_UPDATE: begin
            if (act_sel) begin
              start_q[idx_q] <= item_q.now_ms;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.lvl_end) begin
        level_q <= (residual_q == '0) ? '0 : lq_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.load) begin
      elapsed_q  <= (item_q.now_ms >= start_sel) ? item_q.now_ms - start_sel : '0;
      draw_sel_q <= draw_sel;
    end
    if (cmd_i.mul_en) begin
      if (cmd_i.mul_hi) begin
        phi_q <= mul_p;
      end else begin
        plo_q <= mul_p;
      end
    end
    if (cmd_i.div_init) begin
      dq_q  <= eam_pkg::dq_t'(plo_q) + (eam_pkg::dq_t'(phi_q) << eam_pkg::HALF_W);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[eam_pkg::DQ_W-eam_pkg::DIGIT_W-1:0], qbits};
      rem_q <= rem_t_v;
    end
    if (cmd_i.lvl_init) begin
      lq_q   <= residual_q;
      lrem_q <= '0;
    end else if (cmd_i.lvl_step) begin
      lq_q   <= {lq_q[eam_pkg::CHARGE_W-2:0], lvl_ge};
      lrem_q <= lvl_ge ? lvl_diff[eam_pkg::CHARGE_W-1:0]
                       : lvl_trial[eam_pkg::CHARGE_W-1:0];
    end
  end

  assign result_o.residual          = residual_q;
  assign result_o.energy_level      = level_q;
  assign result_o.node_down         = (residual_q == '0);
  assign result_o.component_on_time = in_range ? ontime_sel : '0;

endmodule

// File: rtl/energy_accounting_meter_top.sv
// top level of the energy accounting meter
//
//   channel   handshake                  payload
//   command   start / busy               item_i (func, component, now_ms, draw_ua)
//   result    done_o strobe, one cycle   result_o (residual, energy_level, node_down,
//                                         component_on_time)
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one transaction at a time; busy stays high up to and including the result strobe
// on or off of an active component: load, multiply low then high half, byte-wise divide by
// 3600, apply, bit-serial level divider, strobe; inactive: no multiply or divide
// unused code: strobe only; update: each component in turn, then the level divider
// reset clears all component state at once, no clearing pass
// config is always ready; the result cannot be held off
module energy_accounting_meter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  eam_pkg::item_t                item_i,
  output logic                          done_o,
  output eam_pkg::result_t              result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [eam_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  eam_pkg::charge_t              cfg_data_i
);

  eam_pkg::cmd_t    cmd;
  eam_pkg::status_t st;

  assign cfg_ready_o = 1'b1;

  eam_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .st_i    (st),
    .cmd_o   (cmd)
  );

  eam_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_wr_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .result_o    (result_o)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench of the energy accounting meter: directed table, then randomised phases
module tb_top;

  localparam logic [eam_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;
  localparam int unsigned HOUR_DIV = 3600;
  localparam eam_pkg::tstamp_t TIME_MAX = '1;
  localparam eam_pkg::charge_t CHARGE_MAX = '1;
  localparam eam_pkg::draw_t DRAW_MAX = '1;
  localparam eam_pkg::charge_t BOOT_CHARGE = 40'd1_000_000_000;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_IDLE [NUM_PHASES] = '{0, 48, 7, 48, 7, 0};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{260, 260, 100, 260, 260, 160};
  localparam int MAX_SHOWN = 40;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    eam_pkg::item_t   stim;
    bit               typed;
    eam_pkg::result_t want;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  eam_pkg::item_t   item_i = '0;
  logic             done_o;
  eam_pkg::result_t result_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [eam_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  eam_pkg::charge_t cfg_data_i = '0;

  // predicted meter state
  bit               live_q [eam_pkg::NUM_COMPONENTS] = '{default: 1'b0};
  eam_pkg::tstamp_t since_q [eam_pkg::NUM_COMPONENTS] = '{default: '0};
  eam_pkg::draw_t   load_q [eam_pkg::NUM_COMPONENTS] = '{default: '0};
  eam_pkg::tstamp_t on_ms_q [eam_pkg::NUM_COMPONENTS] = '{default: '0};
  eam_pkg::charge_t charge_q = BOOT_CHARGE;
  eam_pkg::charge_t level_q = '0;
  eam_pkg::charge_t per_level_q = 40'd10_000_000;

  eam_pkg::result_t pending_q [$];
  int               mismatches = 0;

  row_t plan [18] = '{
    '{'{FUNC_NOP, 3'd0, 48'd0, 20'd0}, 1'b1,
      '{BOOT_CHARGE, 40'd0, 1'b0, 48'd0}},
    '{'{eam_pkg::FUNC_OFF, 3'd0, 48'd0, 20'd0}, 1'b1,
      '{BOOT_CHARGE, 40'd100, 1'b0, 48'd0}},
    '{'{eam_pkg::FUNC_ON, 3'd7, 48'd0, DRAW_MAX}, 1'b1,
      '{BOOT_CHARGE, 40'd100, 1'b0, 48'd0}},
    '{'{eam_pkg::FUNC_ON, 3'd0, 48'd1000, 20'd3600}, 1'b0, '0},
    '{'{eam_pkg::FUNC_OFF, 3'd0, 48'd4600, 20'd0}, 1'b0, '0},
    '{'{eam_pkg::FUNC_ON, 3'd1, 48'd10000, 20'd1}, 1'b0, '0},
    '{'{eam_pkg::FUNC_OFF, 3'd1, 48'd5000, 20'd0}, 1'b0, '0},
    '{'{eam_pkg::FUNC_ON, 3'd3, 48'd20000, 20'd720}, 1'b0, '0},
    '{'{eam_pkg::FUNC_ON, 3'd3, 48'd25000, 20'd0}, 1'b0, '0},
    '{'{eam_pkg::FUNC_UPDATE, 3'd3, 48'd30000, 20'd0}, 1'b0, '0},
    '{'{eam_pkg::FUNC_UPDATE, 3'd7, TIME_MAX, DRAW_MAX}, 1'b1,
      '{40'd0, 40'd0, 1'b1, TIME_MAX}},
    '{'{eam_pkg::FUNC_UPDATE, 3'd7, TIME_MAX, 20'd0}, 1'b1,
      '{40'd0, 40'd0, 1'b1, TIME_MAX}},
    '{'{eam_pkg::FUNC_OFF, 3'd7, TIME_MAX, 20'd0}, 1'b1,
      '{40'd0, 40'd0, 1'b1, TIME_MAX}},
    '{'{eam_pkg::FUNC_ON, 3'd7, 48'd0, 20'd5}, 1'b1,
      '{40'd0, 40'd0, 1'b1, TIME_MAX}},
    '{'{eam_pkg::FUNC_OFF, 3'd7, TIME_MAX, 20'd0}, 1'b1,
      '{40'd0, 40'd0, 1'b1, TIME_MAX}},
    '{'{FUNC_NOP, 3'd2, 48'd123, DRAW_MAX}, 1'b0, '0},
    '{'{eam_pkg::FUNC_ON, 3'd4, 48'd1, 20'd1}, 1'b0, '0},
    '{'{eam_pkg::FUNC_UPDATE, 3'd0, 48'd0, 20'd0}, 1'b0, '0}
  };

  energy_accounting_meter_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void settle_level();
    if (charge_q == '0) level_q = '0;
    else if (per_level_q == '0) level_q = CHARGE_MAX;
    else level_q = charge_q / per_level_q;
  endfunction

  function automatic void end_interval(int c, eam_pkg::tstamp_t now);
    eam_pkg::tstamp_t span;
    logic [eam_pkg::TIME_W:0] total;
    logic [eam_pkg::TIME_W+eam_pkg::DRAW_W-1:0] spent;
    if (live_q[c]) begin
      live_q[c] = 1'b0;
      span = (now >= since_q[c]) ? now - since_q[c] : '0;
      total = {1'b0, on_ms_q[c]} + {1'b0, span};
      on_ms_q[c] = total[eam_pkg::TIME_W] ? TIME_MAX : total[eam_pkg::TIME_W-1:0];
      spent = {{eam_pkg::DRAW_W{1'b0}}, span};
      spent = (spent * load_q[c]) / HOUR_DIV;
      if (spent >= charge_q) charge_q = '0;
      else charge_q = charge_q - spent[eam_pkg::CHARGE_W-1:0];
    end
    settle_level();
  endfunction

  function automatic void begin_interval(int c, eam_pkg::tstamp_t now, eam_pkg::draw_t d);
    end_interval(c, now);
    since_q[c] = now;
    live_q[c] = 1'b1;
    load_q[c] = d;
  endfunction

  function automatic eam_pkg::result_t predict_event(eam_pkg::item_t it);
    eam_pkg::result_t r;
    bit resume;
    bit in_range;
    in_range = it.component < eam_pkg::NUM_COMPONENTS;
    case (it.func)
      eam_pkg::FUNC_ON: if (in_range) begin_interval(it.component, it.now_ms, it.draw_ua);
      eam_pkg::FUNC_OFF: if (in_range) end_interval(it.component, it.now_ms);
      eam_pkg::FUNC_UPDATE: begin
        for (int i = 0; i < eam_pkg::NUM_COMPONENTS; i++) begin
          resume = live_q[i];
          end_interval(i, it.now_ms);
          if (resume) begin_interval(i, it.now_ms, load_q[i]);
        end
      end
      default: ;
    endcase
    r.residual = charge_q;
    r.energy_level = level_q;
    r.node_down = (charge_q == '0);
    r.component_on_time = in_range ? on_ms_q[it.component] : '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < MAX_SHOWN)
      $display("%0t %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    eam_pkg::result_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(result_o.residual), '0);
      end else begin
        want = pending_q.pop_front();
        if (result_o.residual !== want.residual)
          report_mismatch("residual", 64'(result_o.residual), 64'(want.residual));
        if (result_o.energy_level !== want.energy_level)
          report_mismatch("energy_level", 64'(result_o.energy_level), 64'(want.energy_level));
        if (result_o.node_down !== want.node_down)
          report_mismatch("node_down", 64'(result_o.node_down), 64'(want.node_down));
        if (result_o.component_on_time !== want.component_on_time)
          report_mismatch("component_on_time", 64'(result_o.component_on_time),
                          64'(want.component_on_time));
      end
    end
  end

  // called at a rising edge; leaves start high unless an idle gap follows
  task automatic issue(eam_pkg::item_t it, bit typed, eam_pkg::result_t fixed, int idle_pct);
    eam_pkg::result_t guess;
    item_i <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    guess = predict_event(it);
    pending_q.push_back(typed ? fixed : guess);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 70)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_reg(eam_pkg::cfg_idx_e idx, eam_pkg::charge_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    if (idx == eam_pkg::CFG_FULL_CHARGE) charge_q = value;
    else per_level_q = value;
  endtask

  initial begin
    eam_pkg::item_t   it;
    eam_pkg::tstamp_t clock_ms;
    eam_pkg::charge_t full;
    eam_pkg::charge_t per_level;
    int               pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) issue(plan[k].stim, plan[k].typed, plan[k].want, 0);

    clock_ms = eam_pkg::tstamp_t'($urandom_range(0, 100000));
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (start) start <= 1'b0;
      drain();
      case (p)
        0: begin
          full = CHARGE_MAX;
          per_level = 40'd1;
        end
        1: begin
          full = eam_pkg::charge_t'({$urandom, $urandom});
          per_level = full / 100;
          if (per_level == '0) per_level = 40'd1;
        end
        2: begin
          full = '0;
          per_level = CHARGE_MAX;
        end
        3: begin
          full = 40'd5_000_000;
          per_level = '0;
        end
        4: begin
          full = BOOT_CHARGE;
          per_level = 40'd10_000_000;
        end
        default: begin
          full = eam_pkg::charge_t'($urandom_range(0, 200_000_000));
          per_level = eam_pkg::charge_t'({$urandom, $urandom});
        end
      endcase
      write_reg(eam_pkg::CFG_CHARGE_PER_LEVEL, per_level);
      @(posedge clk_i);
      write_reg(eam_pkg::CFG_FULL_CHARGE, full);

      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        pick = $urandom_range(99);
        if (pick < 40) it.func = eam_pkg::FUNC_ON;
        else if (pick < 75) it.func = eam_pkg::FUNC_OFF;
        else if (pick < 90) it.func = eam_pkg::FUNC_UPDATE;
        else it.func = FUNC_NOP;
        it.component = eam_pkg::COMP_W'($urandom_range(0, eam_pkg::NUM_COMPONENTS - 1));
        it.draw_ua = eam_pkg::draw_t'($urandom);
        pick = $urandom_range(99);
        if (pick < 80) begin
          clock_ms = clock_ms + eam_pkg::tstamp_t'($urandom_range(0, 4000));
          it.now_ms = clock_ms;
        end else if (pick < 90) begin
          it.now_ms = eam_pkg::tstamp_t'({$urandom, $urandom});
        end else begin
          it.now_ms = clock_ms - eam_pkg::tstamp_t'($urandom_range(0, 10000));
        end
        issue(it, 1'b0, '0, PHASE_IDLE[p]);
      end
    end

    if (start) start <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("energy_accounting_meter_top: match");
    end else begin
      $display("energy_accounting_meter_top: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("energy_accounting_meter_top: mismatch");
    $finish;
  end

endmodule
